// ----- rtl/cwpf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cwpf_pkg: shared types and constants of the coverage window peak finder
//
// Holds the controller states, the command and status groups that pass
// between the controller and the datapath, register indexes and widths.
// ----------------------------------------------------------------------------
package cwpf_pkg;

   // Field and register widths.
   localparam int COUNT_W = 16;
   localparam int VALUE_W = 24;
   localparam int SCALE_W = 24;
   localparam int WSIZE_W = 11;
   localparam int RECIP_W = 17;
   localparam int SUM_W   = 34;
   localparam int PROD_W  = COUNT_W + SCALE_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_SCALE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_CONTROL       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_RECIPROCAL = 2'd3;

   // Register values after reset.
   localparam logic [SCALE_W-1:0] RST_CONTROL_SCALE     = 24'd65536;
   localparam logic               RST_USE_CONTROL       = 1'b1;
   localparam logic [WSIZE_W-1:0] RST_WINDOW_SIZE       = 11'd100;
   localparam logic [RECIP_W-1:0] RST_WINDOW_RECIPROCAL = 17'd655;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VALUE,
      ST_SUM,
      ST_BEST,
      ST_MUL,
      ST_MEAN
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic value;
      logic sum;
      logic best;
      logic mul;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ----- rtl/cwpf_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cwpf_ctrl: sequencing controller of the coverage window peak finder
//
// Steps one position through value, sum and peak stages, and at the end of
// an interval through the mean multiply and the result load.
// ----------------------------------------------------------------------------
module cwpf_ctrl
   import cwpf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_VALUE;
            end
         end
         ST_VALUE: begin
            cmd.value = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_BEST;
         end
         ST_BEST: begin
            cmd.best = 1'b1;
            state_in = status.last ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_MEAN;
         end
         ST_MEAN: begin
            // The result waits here until the output register is free.
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// ----- rtl/cwpf_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cwpf_datapath: arithmetic, ring memory and registers of the peak finder
//
// Forms the coverage value, keeps the window ring and running sum, tracks
// the best full-window sum and turns it into a mean at the interval end.
// ----------------------------------------------------------------------------
module cwpf_datapath
   import cwpf_pkg::*;
#(
   parameter int MAX_WINDOW = 1024
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic [COUNT_W-1:0]     req_sample_count,
   input  wire logic [COUNT_W-1:0]     req_control_count,
   input  wire logic                   req_interval_end,
   input  wire logic                   csr_write,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [VALUE_W-1:0]          rsp_peak_mean,
   output logic                        rsp_peak_valid
);

   localparam int PTR_W = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int HALF_W = SUM_W / 2;
   localparam int PP_W = HALF_W + RECIP_W;
   localparam int TOT_W = SUM_W + RECIP_W;

   // Configuration registers.
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic               use_ctl_ff, use_ctl_in;
   logic [WSIZE_W-1:0] wsize_ff, wsize_in;
   logic [RECIP_W-1:0] recip_ff, recip_in;

   // Interval state.
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]   best_ff, best_in;
   logic               seen_ff, seen_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Per-item payload registers.
   logic [COUNT_W-1:0] sample_ff, sample_in;
   logic [PROD_W-1:0]  neg_ff, neg_in;
   logic               last_ff, last_in;
   logic [VALUE_W-1:0] old_ff;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [PP_W-1:0]    lo_ff, lo_in;
   logic [PP_W-1:0]    hi_ff, hi_in;
   logic [VALUE_W-1:0] mean_ff, mean_in;
   logic               pvalid_ff, pvalid_in;

   // Window ring, one read and one write port.
   logic [VALUE_W-1:0] ring_mem [MAX_WINDOW];

   logic [CNT_W-1:0]   win;
   logic               full;
   logic [PROD_W-1:0]  pos;
   logic [PROD_W-1:0]  diff;
   logic [TOT_W-1:0]   total;
   logic [TOT_W-17:0]  mean_wide;
   logic               out_free;

   // Effective window: zero acts as one, large sizes clip to the ring depth.
   always_comb begin
      if (wsize_ff == '0) begin
         win = CNT_W'(1);
      end else if (32'(wsize_ff) > 32'(MAX_WINDOW)) begin
         win = CNT_W'(MAX_WINDOW);
      end else begin
         win = CNT_W'(wsize_ff);
      end
   end

   assign full     = (fill_ff >= win);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pos      = PROD_W'({sample_ff, 16'b0});
   assign diff     = pos - neg_ff;
   assign total    = {hi_ff, {HALF_W{1'b0}}} + TOT_W'(lo_ff);
   assign mean_wide = total[TOT_W-1:16];

   // Next values of the control registers.
   always_comb begin
      scale_in     = scale_ff;
      use_ctl_in   = use_ctl_ff;
      wsize_in     = wsize_ff;
      recip_in     = recip_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      best_in      = best_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // Register writes; a new window size drops the open interval.
      if (csr_write) begin
         case (csr_index)
            CSR_CONTROL_SCALE: begin
               scale_in = csr_data[SCALE_W-1:0];
            end
            CSR_USE_CONTROL: begin
               use_ctl_in = csr_data[0];
            end
            CSR_WINDOW_SIZE: begin
               wsize_in = csr_data[WSIZE_W-1:0];
               ptr_in   = '0;
               fill_in  = '0;
               sum_in   = '0;
               best_in  = '0;
               seen_in  = 1'b0;
            end
            CSR_WINDOW_RECIPROCAL: begin
               recip_in = csr_data[RECIP_W-1:0];
            end
            default: begin
            end
         endcase
      end

      // Slide the window: add the new value, drop the oldest once full.
      if (cmd.sum) begin
         sum_in = sum_ff + SUM_W'(value_ff) - (full ? SUM_W'(old_ff) : '0);
         if (CNT_W'(ptr_ff) + CNT_W'(1) == win) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + PTR_W'(1);
         end
         if (!full) begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end

      // Keep the first largest full-window sum.
      if (cmd.best && full) begin
         if (!seen_ff || sum_ff > best_ff) begin
            best_in = sum_ff;
         end
         seen_in = 1'b1;
      end

      // Load the result and clear the interval.
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         ptr_in       = '0;
         fill_in      = '0;
         sum_in       = '0;
         best_in      = '0;
         seen_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= RST_CONTROL_SCALE;
         use_ctl_ff   <= RST_USE_CONTROL;
         wsize_ff     <= RST_WINDOW_SIZE;
         recip_ff     <= RST_WINDOW_RECIPROCAL;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         best_ff      <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scale_ff     <= scale_in;
         use_ctl_ff   <= use_ctl_in;
         wsize_ff     <= wsize_in;
         recip_ff     <= recip_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         best_ff      <= best_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next values of the payload registers.
   always_comb begin
      sample_in = sample_ff;
      neg_in    = neg_ff;
      last_in   = last_ff;
      value_in  = value_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mean_in   = mean_ff;
      pvalid_in = pvalid_ff;

      // Capture the beat and form the scaled control product.
      if (cmd.load) begin
         sample_in = req_sample_count;
         last_in   = req_interval_end;
         neg_in    = PROD_W'(req_control_count) * PROD_W'(scale_ff);
      end

      // Coverage value in Q16.8, clamped at zero.
      if (cmd.value) begin
         if (!use_ctl_ff) begin
            value_in = {sample_ff, 8'b0};
         end else if (pos <= neg_ff) begin
            value_in = '0;
         end else begin
            value_in = diff[31:8];
         end
      end

      // Best sum times reciprocal as two half-width partial products.
      if (cmd.mul) begin
         lo_in = PP_W'(best_ff[HALF_W-1:0]) * PP_W'(recip_ff);
         hi_in = PP_W'(best_ff[SUM_W-1:HALF_W]) * PP_W'(recip_ff);
      end

      // Mean with saturation; zero when no full window was seen.
      if (cmd.emit) begin
         pvalid_in = seen_ff;
         if (!seen_ff) begin
            mean_in = '0;
         end else if (|mean_wide[TOT_W-17:VALUE_W]) begin
            mean_in = '1;
         end else begin
            mean_in = mean_wide[VALUE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      neg_ff    <= neg_in;
      last_ff   <= last_in;
      value_ff  <= value_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mean_ff   <= mean_in;
      pvalid_ff <= pvalid_in;
   end

   // Ring memory: oldest value read on load, new value written on sum.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         old_ff <= ring_mem[ptr_ff];
      end
      if (cmd.sum) begin
         ring_mem[ptr_ff] <= value_ff;
      end
   end

   assign status.last     = last_ff;
   assign status.out_free = out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_peak_mean  = mean_ff;
   assign rsp_peak_valid = pvalid_ff;

endmodule
`default_nettype wire

// ----- rtl/coverage_window_peak_finder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// coverage_window_peak_finder_core: sliding-window coverage peak finder
//
// Channel   Direction  Ports
// req       in         req_valid, req_stall, req_sample_count,
//                      req_control_count, req_interval_end
// rsp       out        rsp_valid, rsp_stall, rsp_peak_mean, rsp_peak_valid
// csr       in         csr_write, csr_index, csr_data
//
// A position passes through accept with ring read and control multiply,
// coverage value, window sum with ring write, peak compare.
// A position that ends an interval then passes the mean multiply and
// result load; the load waits while an earlier result is stalled.
// Reset is synchronous; the ring is not cleared, the fill count guards it.
// One result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module coverage_window_peak_finder_core
   import cwpf_pkg::*;
#(
   parameter int MAX_WINDOW = 1024
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [COUNT_W-1:0]     req_sample_count,
   input  wire logic [COUNT_W-1:0]     req_control_count,
   input  wire logic                   req_interval_end,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [VALUE_W-1:0]          rsp_peak_mean,
   output logic                        rsp_peak_valid,
   input  wire logic                   csr_write,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;

   // Sequencing controller.
   cwpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, ring and result register.
   cwpf_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_sample_count  (req_sample_count),
      .req_control_count (req_control_count),
      .req_interval_end  (req_interval_end),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_peak_mean     (rsp_peak_mean),
      .rsp_peak_valid    (rsp_peak_valid)
   );

endmodule
`default_nettype wire
